// ===== hdl/framed_sample_packetizer_unit_macros.svh =====
// Assertion macros used by the packetizer port checker.
`ifndef FRAMED_SAMPLE_PACKETIZER_UNIT_MACROS_SVH
`define FRAMED_SAMPLE_PACKETIZER_UNIT_MACROS_SVH

// Property checked on i_clk, ignored while i_rst_n is low.
`define FSPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on i_clk at every edge, reset included.
`define FSPU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/fsp_pkg.sv =====
// Shared types and constants of the framed sample packetizer.
`default_nettype none

package fsp_pkg;

    // Default number of raw samples per outgoing packet
    localparam int RAW_SAMPLES_DEF = 9;
    // Packet header bytes: sequence index, quality value
    localparam int HEAD_BYTES      = 2;
    // Payload bytes kept per frame
    localparam int HEAD_KEEP       = 4;

    // Register reset values
    localparam logic [7:0] SYNC_RST    = 8'd170;
    localparam logic [7:0] RAW_RST     = 8'd2;
    localparam logic [7:0] QUALITY_RST = 8'd3;
    localparam logic [7:0] LIMIT_RST   = 8'd255;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SYNC    = 2'd0,
        CFG_RAW     = 2'd1,
        CFG_QUALITY = 2'd2,
        CFG_LIMIT   = 2'd3
    } t_cfg_reg;

    // Frame parser phase
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SYNC2   = 2'd1,
        PH_LEN     = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    // Top level control state
    typedef enum logic {
        ST_RECV = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    // Frame completion event from parser to top level
    typedef struct packed {
        logic        raw_hit;
        logic        qual_hit;
        logic [15:0] sample;   // {payload byte 3, payload byte 2}
        logic [7:0]  quality;  // payload byte 1
    } t_frame_evt;

endpackage

`default_nettype wire

// ===== hdl/framed_sample_packetizer_unit.sv =====
// Top level: frames raw samples from a byte stream and emits sample packets.
//
//   Channel  Dir  Payload                          Transfer
//   s_axis   in   tdata[7:0] rx_byte               tvalid & tready
//   m_axis   out  tdata[7:0] out_byte, tlast       tvalid & tready
//   cfg      in   i_cfg_idx[1:0], i_cfg_data[7:0]  i_cfg_we
//
// Input bytes are taken one per cycle while no packet is being emitted.
// A packet of HEAD_BYTES + 2*RAW_SAMPLES bytes leaves one byte at a time: the
// sample memory read is registered, then the output register is loaded.
// Input is held off from the completing frame byte until the last packet byte
// is loaded. Reset is synchronous; the sample memory is not cleared, each entry
// is written before a packet reads it.
// Output stalls only delay the emission; nothing is dropped.
`default_nettype none

module framed_sample_packetizer_unit #(
    parameter int RAW_SAMPLES = fsp_pkg::RAW_SAMPLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // last_byte
    // configuration writes
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import fsp_pkg::*;

    localparam int PKT_BYTES = HEAD_BYTES + 2 * RAW_SAMPLES;
    localparam int ECW       = $clog2(PKT_BYTES);
    localparam int AW        = (RAW_SAMPLES > 1) ? $clog2(RAW_SAMPLES) : 1;
    localparam int SCW       = $clog2(RAW_SAMPLES + 1);
    localparam logic [ECW-1:0] POS_INDEX   = ECW'(0);
    localparam logic [ECW-1:0] POS_QUALITY = ECW'(1);
    localparam logic [ECW-1:0] POS_LAST    = ECW'(PKT_BYTES - 1);

    // configuration registers
    logic [7:0]     r_sync, r_raw, r_qual, r_limit;

    // control state
    t_state         r_state, n_state;
    logic [ECW-1:0] r_emit_cnt, n_emit_cnt;
    logic           r_fetched, n_fetched;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_seq, n_seq;
    logic [7:0]     r_quality, n_quality;
    logic [AW-1:0]  r_sample_cnt, n_sample_cnt;

    // output payload
    logic [7:0]     r_out_byte;
    logic           r_out_last;

    // sample memory, one 16-bit word per sample
    logic [15:0]    r_mem [RAW_SAMPLES];
    logic [15:0]    r_rd_word;

    t_frame_evt     evt;
    logic           take;
    logic           sample_done;
    logic           out_free;
    logic           load;
    logic           last_k;
    logic [ECW-1:0] emit_j;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     emit_byte;

    assign s_axis_tready = (r_state == ST_RECV);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    fsp_frame_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (s_axis_tdata),
        .i_sync      (r_sync),
        .i_raw_code  (r_raw),
        .i_qual_code (r_qual),
        .o_evt       (evt)
    );

    // Emission datapath: read address and byte select
    always_comb begin
        emit_j  = r_emit_cnt - ECW'(HEAD_BYTES);
        rd_addr = (r_emit_cnt < ECW'(HEAD_BYTES)) ? '0 : AW'(emit_j >> 1);
        priority if (r_emit_cnt == POS_INDEX) begin
            emit_byte = r_seq;
        end else if (r_emit_cnt == POS_QUALITY) begin
            emit_byte = r_quality;
        end else begin
            emit_byte = emit_j[0] ? r_rd_word[15:8] : r_rd_word[7:0];
        end
    end

    assign sample_done = evt.raw_hit && (SCW'(r_sample_cnt) + SCW'(1) == SCW'(RAW_SAMPLES));
    assign out_free    = !r_out_valid || m_axis_tready;
    assign load        = (r_state == ST_EMIT) && r_fetched && out_free;
    assign last_k      = (r_emit_cnt == POS_LAST);

    // Next state and control values
    always_comb begin
        n_state      = r_state;
        n_emit_cnt   = r_emit_cnt;
        n_fetched    = r_fetched;
        n_seq        = r_seq;
        n_quality    = r_quality;
        n_sample_cnt = r_sample_cnt;

        unique case (r_state)
            ST_RECV: begin
                if (take && evt.qual_hit) n_quality = evt.quality;
                if (take && evt.raw_hit) begin
                    n_sample_cnt = sample_done ? '0 : r_sample_cnt + AW'(1);
                end
                if (take && sample_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (load) begin
                    n_fetched = 1'b0;
                    if (last_k) begin
                        n_emit_cnt = '0;
                        n_state    = ST_RECV;
                        n_seq      = ((r_seq >= r_limit) ? 8'd0 : r_seq) + 8'd1;
                    end else begin
                        n_emit_cnt = r_emit_cnt + ECW'(1);
                    end
                end else begin
                    // read of the current address has completed: read data valid
                    n_fetched = 1'b1;
                end
            end
            default: n_state = ST_RECV;
        endcase

        // output register occupancy
        if (load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RECV;
            r_emit_cnt   <= '0;
            r_fetched    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_seq        <= '0;
            r_quality    <= '0;
            r_sample_cnt <= '0;
        end else begin
            r_state      <= n_state;
            r_emit_cnt   <= n_emit_cnt;
            r_fetched    <= n_fetched;
            r_out_valid  <= n_out_valid;
            r_seq        <= n_seq;
            r_quality    <= n_quality;
            r_sample_cnt <= n_sample_cnt;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= SYNC_RST;
            r_raw   <= RAW_RST;
            r_qual  <= QUALITY_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_SYNC:    r_sync  <= i_cfg_data;
                CFG_RAW:     r_raw   <= i_cfg_data;
                CFG_QUALITY: r_qual  <= i_cfg_data;
                CFG_LIMIT:   r_limit <= i_cfg_data;
                default:     r_sync  <= r_sync;
            endcase
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= emit_byte;
            r_out_last <= last_k;
        end
    end

    // Sample memory: write on raw frame, registered read
    always_ff @(posedge i_clk) begin
        if (take && evt.raw_hit) begin
            r_mem[r_sample_cnt] <= evt.sample;
        end
        r_rd_word <= r_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/fsp_frame_parser.sv =====
// Sync, length and payload tracking of the incoming byte stream.
`default_nettype none

module fsp_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            i_sync,
    input  logic [7:0]            i_raw_code,
    input  logic [7:0]            i_qual_code,
    output fsp_pkg::t_frame_evt   o_evt
);
    import fsp_pkg::*;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_len, n_len;
    logic [8:0]      r_count, n_count;
    logic [3:0][7:0] r_head, n_head;

    logic [3:0][7:0] head_upd;
    logic [8:0]      cnt_inc;
    logic            frame_end;
    logic            is_raw;

    // Phase, length, count and kept head bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_count  = r_count;
        n_head   = r_head;

        // head bytes as they stand after this byte; short frames keep old ones
        head_upd = r_head;
        if (r_count < 9'(HEAD_KEEP)) begin
            head_upd[r_count[1:0]] = i_byte;
        end
        cnt_inc   = r_count + 9'd1;
        frame_end = (r_phase == PH_PAYLOAD) && (cnt_inc > {1'b0, r_len});

        if (i_take) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == i_sync) n_phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    n_phase = (i_byte == i_sync) ? PH_LEN : PH_HUNT;
                end
                PH_LEN: begin
                    n_len   = i_byte;
                    n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_head = head_upd;
                    if (frame_end) begin
                        n_len   = '0;
                        n_count = '0;
                        n_phase = PH_HUNT;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end

        // frame event; raw meaning wins when both codes match
        is_raw         = (head_upd[0] == i_raw_code);
        o_evt.raw_hit  = i_take && frame_end && is_raw;
        o_evt.qual_hit = i_take && frame_end && !is_raw && (head_upd[0] == i_qual_code);
        o_evt.sample   = {head_upd[3], head_upd[2]};
        o_evt.quality  = head_upd[1];
    end

endmodule

`default_nettype wire

// ===== hdl/fsp_checker.sv =====
// Port-level checks of the packetizer, bound to the top level.
`default_nettype none

`include "framed_sample_packetizer_unit_macros.svh"

module fsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // reset empties the output register
    `FSPU_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // input is held off while a packet is still being emitted
    `FSPU_ASSERT(a_no_input_mid_packet,
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready, "input ready during packet")

    // emission only starts on an accepted input byte
    `FSPU_ASSERT(a_ready_falls_on_transfer,
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready),
        "ready fell without input transfer")

    // a stalled output byte holds
    `FSPU_ASSERT(a_out_hold,
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)),
        "stalled output changed")

endmodule

bind framed_sample_packetizer_unit fsp_checker u_fsp_checker (.*);

`default_nettype wire

// ===== tb/framed_sample_packetizer_unit_checker.sv =====
// Checker for the framed sample packetizer: tracks frames, predicts packet bytes, compares.
module framed_sample_packetizer_unit_checker #(
    parameter int RAW_SAMPLES = fsp_pkg::RAW_SAMPLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream, observed
    input  logic       i_rx_tvalid,
    input  logic       i_rx_tready,
    input  logic [7:0] i_rx_tdata,    // [7:0] rx_byte
    // output stream, observed
    input  logic       i_pkt_tvalid,
    input  logic       i_pkt_tready,
    input  logic [7:0] i_pkt_tdata,   // [7:0] out_byte
    input  logic       i_pkt_tlast,   // last_byte
    // configuration writes, observed
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // status to the test top
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fsp_pkg::*;

    localparam int STORE_BYTES = 2 * RAW_SAMPLES;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_pkt_byte;

    // Packet bytes still owed by the block, oldest first
    t_pkt_byte  owed_pkt_bytes[$];
    int         fail_total   = 0;
    int         owed_total   = 0;

    // Register copies
    logic [7:0] sync_val;
    logic [7:0] raw_val;
    logic [7:0] qual_val;
    logic [7:0] limit_val;

    // Frame tracking and packet assembly state
    t_phase     phase;
    logic [7:0] frame_len;
    logic [8:0] byte_cnt;
    logic [7:0] head [HEAD_KEEP];
    logic [7:0] samples [STORE_BYTES];
    logic [4:0] sample_cnt;
    logic [7:0] quality;
    logic [7:0] seq_index;

    assign o_fail_count = fail_total;
    assign o_pending    = owed_total;

    task automatic clear_predictor();
        sync_val   = SYNC_RST;
        raw_val    = RAW_RST;
        qual_val   = QUALITY_RST;
        limit_val  = LIMIT_RST;
        phase      = PH_HUNT;
        frame_len  = '0;
        byte_cnt   = '0;
        sample_cnt = '0;
        quality    = '0;
        seq_index  = '0;
        foreach (head[k]) head[k] = '0;
        foreach (samples[k]) samples[k] = '0;
        owed_pkt_bytes.delete();
    endtask

    // Index, quality, then the sample bytes; last flag on the final one
    task automatic queue_packet();
        t_pkt_byte pb;
        pb.data = seq_index;
        pb.last = 1'b0;
        owed_pkt_bytes.push_back(pb);
        pb.data = quality;
        owed_pkt_bytes.push_back(pb);
        for (int k = 0; k < STORE_BYTES; k++) begin
            pb.data = samples[k];
            pb.last = (k == STORE_BYTES - 1);
            owed_pkt_bytes.push_back(pb);
        end
        if (seq_index >= limit_val) seq_index = '0;
        seq_index = seq_index + 8'd1;
        foreach (samples[k]) samples[k] = '0;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        case (phase)
            PH_HUNT: begin
                if (b == sync_val) phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                // a bad second sync is not reused as a first sync
                if (b == sync_val) phase = PH_LEN;
                else phase = PH_HUNT;
            end
            PH_LEN: begin
                frame_len = b;
                phase     = PH_PAYLOAD;
            end
            default: begin
                if (byte_cnt < HEAD_KEEP) head[byte_cnt[1:0]] = b;
                byte_cnt = byte_cnt + 9'd1;
                if (byte_cnt > {1'b0, frame_len}) begin
                    // frame complete; short frames reuse stale head bytes
                    frame_len = '0;
                    byte_cnt  = '0;
                    phase     = PH_HUNT;
                    if (head[0] == raw_val) begin
                        if (sample_cnt < RAW_SAMPLES) begin
                            samples[2 * sample_cnt]     = head[2];
                            samples[2 * sample_cnt + 1] = head[3];
                        end
                        sample_cnt = sample_cnt + 5'd1;
                    end else if (head[0] == qual_val) begin
                        quality = head[1];
                    end
                    if (sample_cnt >= RAW_SAMPLES) begin
                        sample_cnt = '0;
                        queue_packet();
                    end
                end
            end
        endcase
    endtask

    // Observe every channel at the rising edge
    always @(posedge i_clk) begin : observe
        t_pkt_byte want;
        if (!i_rst_n) begin
            clear_predictor();
        end else begin
            // output transfer against the oldest owed byte
            if (i_pkt_tvalid && i_pkt_tready) begin
                if (owed_pkt_bytes.size() == 0) begin
                    fail_total++;
                    $display("%0t ns: unexpected packet byte: expected none, actual %02h last %0b",
                             $time, i_pkt_tdata, i_pkt_tlast);
                end else begin
                    want = owed_pkt_bytes.pop_front();
                    if (want.data !== i_pkt_tdata) begin
                        fail_total++;
                        $display("%0t ns: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data, i_pkt_tdata);
                    end
                    if (want.last !== i_pkt_tlast) begin
                        fail_total++;
                        $display("%0t ns: last_byte mismatch: expected %0b, actual %0b",
                                 $time, want.last, i_pkt_tlast);
                    end
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_SYNC:    sync_val  = i_cfg_data;
                    CFG_RAW:     raw_val   = i_cfg_data;
                    CFG_QUALITY: qual_val  = i_cfg_data;
                    CFG_LIMIT:   limit_val = i_cfg_data;
                    default: ;
                endcase
            end
            // input transfer
            if (i_rx_tvalid && i_rx_tready) parse_rx_byte(i_rx_tdata);
        end
        owed_total = owed_pkt_bytes.size();
    end

endmodule

// ===== tb/framed_sample_packetizer_unit_test.sv =====
// Test top for the framed sample packetizer: clock, reset, stimulus and verdict.
module framed_sample_packetizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fsp_pkg::*;

    localparam int RAW_SAMPLES    = RAW_SAMPLES_DEF;
    localparam int PHASE_ITEMS    = 18;
    localparam int SETTLE_CYCLES  = 50;
    localparam int DIRECTED_ITEMS = 26;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    int         fail_count;
    int         pending;
    int         rx_sent;
    logic       no_idle;

    // Stimulus copies of the current settings, used to build frames
    logic [7:0] cur_sync;
    logic [7:0] cur_raw;
    logic [7:0] cur_qual;

    // Noise, bad second sync, quality frame, raw frame, short raw frame, other code
    logic [7:0] directed_seq [DIRECTED_ITEMS] = '{
        8'h00, 8'hFF,
        8'hAA, 8'h00,
        8'hAA, 8'hAA, 8'h02, 8'h03, 8'h7F, 8'h01,
        8'hAA, 8'hAA, 8'h03, 8'h02, 8'h00, 8'hFF, 8'h00,
        8'hAA, 8'hAA, 8'h00, 8'h02,
        8'hAA, 8'hAA, 8'h01, 8'h55, 8'h66
    };

    framed_sample_packetizer_unit #(
        .RAW_SAMPLES(RAW_SAMPLES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    framed_sample_packetizer_unit_checker #(
        .RAW_SAMPLES(RAW_SAMPLES)
    ) packet_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_tvalid  (s_axis_tvalid),
        .i_rx_tready  (s_axis_tready),
        .i_rx_tdata   (s_axis_tdata),
        .i_pkt_tvalid (m_axis_tvalid),
        .i_pkt_tready (m_axis_tready),
        .i_pkt_tdata  (m_axis_tdata),
        .i_pkt_tlast  (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // Packet sink: stalls at random with a chance of 9 in 100 unless idling is off
    always @(negedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 9);
    end

    // One byte transfer on the input stream, with random gaps before it
    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        rx_sent++;
    endtask

    // Stop sending, wait for all owed packet bytes, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Back-to-back register writes; only called while the block is quiet
    task automatic write_settings(input logic [7:0] sync_v, raw_v, qual_v, limit_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SYNC;
        i_cfg_data <= sync_v;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RAW;
        i_cfg_data <= raw_v;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_QUALITY;
        i_cfg_data <= qual_v;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= limit_v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_sync = sync_v;
        cur_raw  = raw_v;
        cur_qual = qual_v;
    endtask

    // Full frame: two syncs, length, code, then len random payload bytes
    task automatic send_frame(input logic [7:0] code, input logic [7:0] len);
        send_byte(cur_sync);
        send_byte(cur_sync);
        send_byte(len);
        send_byte(code);
        for (int k = 0; k < len; k++) send_byte(8'($urandom));
    endtask

    // Mostly well-formed frames, some noise and broken sync pairs
    task automatic send_random_unit();
        int         pick;
        logic [7:0] code;
        logic [7:0] len;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_byte(8'($urandom));
        end else if (pick < 13) begin
            send_byte(cur_sync);
            send_byte(cur_sync ^ (8'd1 << $urandom_range(7)));
        end else begin
            pick = $urandom_range(99);
            if (pick < 75) code = cur_raw;
            else if (pick < 87) code = cur_qual;
            else code = 8'($urandom);
            if ($urandom_range(99) < 70) len = 8'd3;
            else len = 8'($urandom_range(7));
            send_frame(code, len);
        end
    endtask

    task automatic run_random(input int n_items);
        int start;
        start = rx_sent;
        while (rx_sent - start < n_items) send_random_unit();
    endtask

    // Stimulus
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SYNC;
        i_cfg_data    = '0;
        no_idle       = 1'b0;
        rx_sent       = 0;
        cur_sync      = SYNC_RST;
        cur_raw       = RAW_RST;
        cur_qual      = QUALITY_RST;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at reset settings
        foreach (directed_seq[k]) send_byte(directed_seq[k]);
        settle();

        // fresh codes, no gaps and no stalls
        write_settings(8'h55, 8'h10, 8'h20, 8'hFF);
        no_idle <= 1'b1;
        run_random(PHASE_ITEMS);
        settle();
        no_idle <= 1'b0;

        // low extremes, index limit zero
        write_settings(8'h00, 8'h00, 8'hFF, 8'h00);
        run_random(PHASE_ITEMS);
        settle();

        // high extremes, raw and quality codes equal, index limit one
        write_settings(8'hFF, 8'hFF, 8'hFF, 8'h01);
        run_random(PHASE_ITEMS);
        settle();

        // small index limit to force an index wrap, then the longest frame without gaps
        write_settings(SYNC_RST, RAW_RST, QUALITY_RST, 8'h03);
        no_idle <= 1'b1;
        send_frame(cur_raw, 8'hFF);
        no_idle <= 1'b0;
        run_random(PHASE_ITEMS);
        settle();

        // hold the input right after a packet is due, until it has drained
        write_settings(8'h3C, 8'h81, 8'h7E, 8'h02);
        while (pending == 0) send_random_unit();
        settle();
        run_random(PHASE_ITEMS / 2);
        settle();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
